@@ rtl/kvt_pkg.sv @@
// Package for the key/value table: request and status codes, and the
// command and status structs passed between controller and datapath.
// No dependencies.
package kvt_pkg;

	localparam logic [1:0] ACT_READ   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture a new request and rewind the slot counter
		logic clear;   // write one slot invalid during the clearing pass
		logic scan;    // step the slot scan by one
		logic finish;  // act on the scan outcome and present the result
	} kvt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;  // clearing pass is at the last slot
		logic scan_end;  // all slots have been issued for reading
	} kvt_sts_t;

endpackage

@@ rtl/kvt_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
// No dependencies.
module kvt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/kvt_dp.sv @@
// Datapath of the key/value table: request registers, slot counter, the
// key and value memories, the scan trackers and the result registers.
// Depends on kvt_pkg and kvt_ram.
module kvt_dp import kvt_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  kvt_cmd_t    cmd,
	output kvt_sts_t    sts,
	input  logic [1:0]  action,
	input  logic [63:0] key,
	input  logic [63:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] read_value
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1) > 0 ? $clog2(ENTRIES + 1) : 1;
	localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
	localparam logic [CW-1:0] END  = CW'(ENTRIES);

	logic [1:0]            act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         cnt_q;
	logic                  rd_en_s1;
	logic [AW-1:0]         idx_s1;

	logic                  hit_q;
	logic [AW-1:0]         hit_idx_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  free_q;
	logic [AW-1:0]         free_idx_q;

	logic                  done_q;
	logic [1:0]            status_q;
	logic [63:0]           read_value_q;

	logic                  k_wr_en;
	logic [AW-1:0]         k_wr_addr;
	logic [KEY_BITS:0]     k_wr_data;
	logic [KEY_BITS:0]     k_rd_data;
	logic                  v_wr_en;
	logic [AW-1:0]         v_wr_addr;
	logic [VALUE_BITS-1:0] v_rd_data;

	logic                  match;
	logic                  is_free;

	// Key memory word: valid mark on top, key below.
	kvt_ram #(.WIDTH(KEY_BITS + 1), .DEPTH(ENTRIES)) u_key_ram (
		.clk     (clk),
		.wr_en   (k_wr_en),
		.wr_addr (k_wr_addr),
		.wr_data (k_wr_data),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (k_rd_data)
	);

	kvt_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
		.clk     (clk),
		.wr_en   (v_wr_en),
		.wr_addr (v_wr_addr),
		.wr_data (val_q),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (v_rd_data)
	);

	assign match   = rd_en_s1 && k_rd_data[KEY_BITS] && (k_rd_data[KEY_BITS-1:0] == key_q);
	assign is_free = rd_en_s1 && !k_rd_data[KEY_BITS];

	assign sts.clr_last = (cnt_q == LAST);
	assign sts.scan_end = (cnt_q == END);

	// Key memory writes: clearing pass, deletes during the scan, and new
	// slots filled by a write at the end.
	always_comb begin
		k_wr_en   = 1'b0;
		k_wr_addr = cnt_q[AW-1:0];
		k_wr_data = '0;
		v_wr_en   = 1'b0;
		v_wr_addr = hit_idx_q;
		if (cmd.clear) begin
			k_wr_en = 1'b1;
		end else if (match && act_q == ACT_DELETE) begin
			k_wr_en   = 1'b1;
			k_wr_addr = idx_s1;
			k_wr_data = {1'b0, key_q};
		end else if (cmd.finish && act_q == ACT_WRITE && !hit_q && free_q) begin
			k_wr_en   = 1'b1;
			k_wr_addr = free_idx_q;
			k_wr_data = {1'b1, key_q};
		end
		if (cmd.finish && act_q == ACT_WRITE) begin
			if (hit_q) begin
				v_wr_en = 1'b1;
			end else if (free_q) begin
				v_wr_en   = 1'b1;
				v_wr_addr = free_idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rd_en_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.load) begin
				cnt_q    <= '0;
				rd_en_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_en_s1 <= !sts.scan_end;
				if (!sts.scan_end) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (cmd.clear) begin
				cnt_q    <= cnt_q + 1'b1;
				rd_en_s1 <= 1'b0;
			end else begin
				rd_en_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[AW-1:0];
		if (cmd.load) begin
			act_q  <= action;
			key_q  <= key[KEY_BITS-1:0];
			val_q  <= value[VALUE_BITS-1:0];
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			// The lowest matching slot wins, the highest free slot wins.
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_val_q <= v_rd_data;
			end
			if (is_free) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
		end
		if (cmd.finish) begin
			status_q     <= ST_OK;
			read_value_q <= '0;
			case (act_q)
				ACT_READ: begin
					if (hit_q) begin
						read_value_q <= 64'(hit_val_q);
					end else begin
						status_q <= ST_NOT_FOUND;
					end
				end
				ACT_WRITE: begin
					if (!hit_q && !free_q) begin
						status_q <= ST_FULL;
					end
				end
				ACT_DELETE: begin
					if (!hit_q) begin
						status_q <= ST_NOT_FOUND;
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;

endmodule

@@ rtl/kvt_ctrl.sv @@
// Controller of the key/value table: sequences the clearing pass after
// reset and the scan-then-act steps of each request.
// Depends on kvt_pkg.
module kvt_ctrl import kvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output kvt_cmd_t cmd,
	input  kvt_sts_t sts
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CLEAR = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.clear  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

@@ rtl/key_value_table.sv @@
// Top level of the key/value table: joins the controller and the datapath.
// Depends on kvt_pkg, kvt_ctrl, kvt_dp (and kvt_ram through the datapath).
//
// Usage. The table holds ENTRIES slots, each a valid mark, a key and a value.
// A request item is taken at a rising edge where start is high and busy is
// low; action, key and value are sampled at that edge. Action 0 reads the
// value stored under the key, 1 writes it (updating a matching slot, or else
// filling the highest-numbered free slot), 2 deletes every slot holding it.
// Only the low KEY_BITS of key and the low VALUE_BITS of value are used.
//
// Each item gives exactly one result item, shown on status and read_value
// for a single cycle while done is high. The receiver cannot hold results
// off, and none is needed: busy keeps the next item out until the current
// one is through. status is 0 for success, 1 when a write finds the table
// full and 2 when a read or delete finds no matching key; read_value carries
// the stored value on a successful read and is zero otherwise.
//
// Timing. Every request scans all slots one per cycle through the read port
// of the key and value memories; busy stays high from the accepting edge
// through that scan and the step that acts on its outcome, and done rises
// as busy falls. The next item can be taken in that first idle cycle, so a
// new item is never taken before the last one's result is shown.
// After reset a clearing pass marks every slot invalid, one slot a cycle,
// and busy stays high until that pass is through.
module key_value_table import kvt_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [63:0] key,
	input  logic [63:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] read_value
);

	kvt_cmd_t cmd;
	kvt_sts_t sts;

	// The controller only sees start and the two scan counter flags; all
	// request data stays in the datapath.
	kvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	kvt_dp #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.key        (key),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value)
	);

endmodule

@@ bench/key_value_table_checker.sv @@
`timescale 1ns / 100ps
// Checker for the key/value table: keeps its own copy of the slot table,
// predicts the reply to every accepted request and compares it with done.
// Depends on kvt_pkg for the request and status codes.
module key_value_table_checker import kvt_pkg::*; #(
	parameter int ENTRIES    = 16,
	parameter int KEY_BITS   = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  action,
	input  logic [63:0] key,
	input  logic [63:0] value,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [63:0] read_value,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_value;
	} table_reply_t;

	localparam logic [63:0] KEY_MASK =
		(KEY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);
	localparam logic [63:0] VALUE_MASK =
		(VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);

	logic        slot_used [ENTRIES];
	logic [63:0] slot_key  [ENTRIES];
	logic [63:0] slot_val  [ENTRIES];

	table_reply_t replies_due[$];

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic record_failure(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// Applies one request to the table copy and returns the reply it gives.
	function automatic table_reply_t apply_request(input logic [1:0] act,
		input logic [63:0] k_in, input logic [63:0] v_in);
		table_reply_t reply;
		logic [63:0]  k;
		logic [63:0]  v;
		int           hit;
		int           free_idx;
		k = k_in & KEY_MASK;
		v = v_in & VALUE_MASK;
		reply.status = ST_OK;
		reply.read_value = '0;
		hit = -1;
		free_idx = -1;
		// Descending scan leaves the lowest matching slot in hit.
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (slot_used[i] && slot_key[i] == k)
				hit = i;
		case (act)
			ACT_READ: begin
				if (hit >= 0)
					reply.read_value = slot_val[hit];
				else
					reply.status = ST_NOT_FOUND;
			end
			ACT_WRITE: begin
				if (hit >= 0) begin
					slot_val[hit] = v;
				end else begin
					for (int i = 0; i < ENTRIES; i++)
						if (!slot_used[i])
							free_idx = i;
					if (free_idx >= 0) begin
						slot_used[free_idx] = 1'b1;
						slot_key[free_idx] = k;
						slot_val[free_idx] = v;
					end else begin
						reply.status = ST_FULL;
					end
				end
			end
			ACT_DELETE: begin
				if (hit >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot_used[i] && slot_key[i] == k)
							slot_used[i] = 1'b0;
				end else begin
					reply.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		table_reply_t due;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				slot_used[i] = 1'b0;
			replies_due.delete();
		end else begin
			if (done) begin
				if (replies_due.size() == 0) begin
					record_failure($sformatf("result with nothing outstanding: status %0d value %h",
						status, read_value));
				end else begin
					due = replies_due.pop_front();
					if (status !== due.status)
						record_failure($sformatf("status: expected %0d, got %0d",
							due.status, status));
					if (read_value !== due.read_value)
						record_failure($sformatf("read_value: expected %h, got %h",
							due.read_value, read_value));
				end
			end
			if (start && !busy)
				replies_due.push_back(apply_request(action, key, value));
		end
		outstanding <= replies_due.size();
	end

endmodule

@@ bench/key_value_table_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the key/value table: clock, reset, request stimulus and
// the verdict. Depends on kvt_pkg, key_value_table and key_value_table_checker.
module key_value_table_tb;
	import kvt_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 64;

	// Random requests that touch the table; undefined codes come on top.
	localparam int RANDOM_ITEMS = 1525;
	// The last stretch of the run has no gaps between items.
	localparam int QUIET_TAIL = 200;
	// The random part alternates between filling and draining the table.
	localparam int PHASE_LEN = 120;
	// More keys than slots, so that the filling phases reach a full table.
	localparam int POOL_SIZE = 24;

	// The block ignores this code; the package leaves it unnamed.
	localparam logic [1:0] ACT_UNDEFINED = 2'd3;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        start  = 1'b0;
	logic [1:0]  action = ACT_READ;
	logic [63:0] key    = '0;
	logic [63:0] value  = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [63:0] read_value;

	int unsigned mismatches;
	int unsigned outstanding;

	logic [63:0] key_pool  [POOL_SIZE];
	logic [63:0] fill_keys [ENTRIES];

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop, several times the slowest correct run.
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	key_value_table #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.key        (key),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value)
	);

	key_value_table_checker #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.key         (key),
		.value       (value),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Presents one request and returns at the edge that takes it. The block is
	// sampled straight after the edge, so busy still shows its value from
	// before that edge, which is what decides acceptance. When the next item
	// follows at once, start simply stays high: it is only ever assigned once
	// per edge.
	task automatic issue(input logic [1:0] act, input logic [63:0] k, input logic [63:0] v);
		start  <= 1'b1;
		action <= act;
		key    <= k;
		value  <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drops start for a few cycles. The request fields carry junk meanwhile,
	// which the block must not take for an item.
	task automatic pause(input int cycles);
		start  <= 1'b0;
		action <= 2'($urandom_range(0, 3));
		key    <= rand64();
		value  <= rand64();
		repeat (cycles) @(posedge clk);
	endtask

	// Filling phases lean on writes, draining phases on deletes; reads and the
	// odd undefined code appear in both.
	function automatic logic [1:0] pick_action(input bit filling);
		int roll;
		roll = $urandom_range(0, 99);
		if (filling) begin
			if (roll < 55) return ACT_WRITE;
			if (roll < 80) return ACT_READ;
			if (roll < 95) return ACT_DELETE;
		end else begin
			if (roll < 20) return ACT_WRITE;
			if (roll < 50) return ACT_READ;
			if (roll < 95) return ACT_DELETE;
		end
		return ACT_UNDEFINED;
	endfunction

	// Mostly keys from the pool, so that requests hit stored entries; now and
	// then a fresh key or one of the extremes.
	function automatic logic [63:0] pick_key();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 88) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (roll < 94) return rand64();
		if (roll < 97) return '0;
		return '1;
	endfunction

	function automatic logic [63:0] pick_value();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10) return '0;
		if (roll < 20) return '1;
		return rand64();
	endfunction

	initial begin
		int         sent;
		int         phase_left;
		int         settle;
		bit         filling;
		bit         idling;
		logic [1:0] act;

		// Every third pool key differs from its neighbour in a single bit, so
		// that the match must compare the whole key word.
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = (i % 3 == 2) ? key_pool[i - 1] ^ (64'd1 << $urandom_range(0, 63))
			                           : rand64();
		fill_keys[0] = '0;
		fill_keys[ENTRIES - 1] = '1;
		for (int i = 1; i < ENTRIES - 1; i++)
			fill_keys[i] = rand64();

		// Reset is held low at the start and released once. The clearing pass
		// that follows keeps busy high, and issue simply waits it out.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. An empty table answers reads and deletes with not
		// found, and an undefined code changes nothing.
		issue(ACT_READ, '0, '0);
		issue(ACT_DELETE, '1, '0);
		issue(ACT_UNDEFINED, '0, '1);
		// Fill every slot, the extreme keys among them, with extreme values at
		// both ends of the table.
		for (int i = 0; i < ENTRIES; i++)
			issue(ACT_WRITE, fill_keys[i],
				(i == 0) ? '1 : (i == ENTRIES - 1) ? 64'd0 : rand64());
		// A new key now finds the table full, but an update of a stored key
		// still succeeds.
		issue(ACT_WRITE, rand64(), rand64());
		issue(ACT_WRITE, '0, 64'h5A5A_A5A5_0F0F_F0F0);
		issue(ACT_READ, '1, '1);
		issue(ACT_READ, '0, '0);
		// A deleted key reads as not found, and its slot takes the next new key.
		issue(ACT_DELETE, '0, '0);
		issue(ACT_READ, '0, '0);
		issue(ACT_WRITE, rand64(), rand64());

		// Random part, in phases that alternately fill and drain the table.
		// Most phases put random gaps between items; some run without any,
		// and the tail of the run has none at all.
		sent = 0;
		phase_left = 0;
		filling = 1'b0;
		idling = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				filling = !filling;
				idling = ($urandom_range(0, 3) != 0);
				phase_left = PHASE_LEN;
			end
			act = pick_action(filling);
			issue(act, pick_key(), pick_value());
			if (act != ACT_UNDEFINED)
				sent++;
			phase_left--;
			if (idling && sent < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
				pause($urandom_range(1, 14));
		end

		// Drain: let the checker see the last acceptance, wait for every reply,
		// then give the block a full request time to show anything stray.
		start <= 1'b0;
		@(posedge clk);
		settle = 0;
		while (outstanding != 0 && settle < 1000) begin
			@(posedge clk);
			settle++;
		end
		repeat (ENTRIES + 4) @(posedge clk);

		if (outstanding != 0)
			$display("%0d expected results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
